@@ sv/ssm_pkg.sv @@
// Shared constants for the sorted set membership block.
// No dependencies; used by sorted_set_membership_core.
`default_nettype none

package ssm_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned SizeWidth       = 7;
  localparam int unsigned CmdWidth        = 2;

  localparam logic [CmdWidth-1:0] CmdClear  = 2'd0;
  localparam logic [CmdWidth-1:0] CmdInsert = 2'd1;
  localparam logic [CmdWidth-1:0] CmdQuery  = 2'd2;

endpackage

`default_nettype wire

@@ sv/sorted_set_membership_core.sv @@
// Sorted set of signed integers with insert, clear and membership query.
// Depends on ssm_pkg for its defaults, field widths and command codes.
`default_nettype none

// The block keeps an ascending, duplicate-free set of up to CAPACITY signed
// 32-bit integers in a one-write, one-read memory. Every item returns one
// result: found, the set size after the item, and overflow. A small
// sequencer drives a single signed comparator. It does a binary search for
// the lower bound, and each probe has a read state and a compare state
// because of the memory's registered read. An insert then moves the entries
// above that position up by one, with a read and a write state per moved
// entry, and writes the new value into the opened gap. A finished item waits
// in its done state while the previous result still waits on a stalled
// output. in_stall_o is high while an item is in work. The result waits in
// an output register, so the next item is taken while an earlier result is
// still stalled. The set is empty after reset, and the memory needs no
// clearing pass.
module sorted_set_membership_core #(
  parameter int unsigned CAPACITY = ssm_pkg::DefaultCapacity
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [ssm_pkg::CmdWidth-1:0]          command_i,
  input  wire logic signed [ssm_pkg::ValueWidth-1:0] value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       found_o,
  output logic [ssm_pkg::SizeWidth-1:0]              set_size_o,
  output logic                                       overflow_o
);

  // Count width holds CAPACITY itself. Address width covers entries
  // 0 .. CAPACITY-1, with at least one bit.
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // The sequencer states, one-hot.
  typedef enum logic [7:0] {
    StIdle   = 8'b00000001,
    StProbe  = 8'b00000010,
    StCmp    = 8'b00000100,
    StDecide = 8'b00001000,
    StShRd   = 8'b00010000,
    StShWr   = 8'b00100000,
    StFill   = 8'b01000000,
    StDone   = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q, out_valid_d;

  // Payload of the item in work. These registers need no reset.
  logic [ssm_pkg::CmdWidth-1:0]          cmd_q, cmd_d;
  logic signed [ssm_pkg::ValueWidth-1:0] val_q, val_d;
  logic [CW-1:0]                         lo_q, lo_d;
  logic [CW-1:0]                         hi_q, hi_d;
  logic [CW-1:0]                         mid_q, mid_d;
  logic [CW-1:0]                         k_q, k_d;
  logic                                  fnd_q, fnd_d;
  logic                                  ovf_q, ovf_d;
  logic                                  res_found_q, res_found_d;
  logic [ssm_pkg::SizeWidth-1:0]         res_size_q, res_size_d;
  logic                                  res_ovf_q, res_ovf_d;

  // The set memory. Entries at and above the count are never read.
  logic signed [ssm_pkg::ValueWidth-1:0] mem_q [CAPACITY];
  logic signed [ssm_pkg::ValueWidth-1:0] rd_data_q;
  logic                                  mem_we;
  logic [AW-1:0]                         mem_waddr;
  logic signed [ssm_pkg::ValueWidth-1:0] mem_wdata;
  logic [AW-1:0]                         mem_raddr;

  logic          in_accept;
  logic          out_load;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_next;
  logic [CW-1:0] lo_cmp;
  logic [CW-1:0] hi_cmp;
  logic [CW-1:0] k_dec;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && (state_q == StIdle);
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // The midpoint of the remaining search window.
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_next = mid_sum[CW:1];
  assign k_dec    = k_q - CW'(1);

  // The shared comparator narrows the window: the lower bound is the first
  // member that is not below the value.
  always_comb begin
    lo_cmp = lo_q;
    hi_cmp = hi_q;
    if (rd_data_q < val_q) begin
      lo_cmp = mid_q + CW'(1);
    end else begin
      hi_cmp = mid_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    k_d         = k_q;
    fnd_d       = fnd_q;
    ovf_d       = ovf_q;
    res_found_d = res_found_q;
    res_size_d  = res_size_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = k_q[AW-1:0];
    mem_wdata   = rd_data_q;
    mem_raddr   = mid_next[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          cmd_d = command_i;
          val_d = value_i;
          lo_d  = '0;
          hi_d  = count_q;
          fnd_d = 1'b0;
          ovf_d = 1'b0;
          if (command_i == ssm_pkg::CmdClear) begin
            count_d = '0;
            state_d = StDone;
          end else if (command_i == ssm_pkg::CmdInsert ||
                       command_i == ssm_pkg::CmdQuery) begin
            state_d = StDecide;
            if (count_q != '0) begin
              state_d = StProbe;
            end
          end else begin
            state_d = StDone;
          end
        end
      end
      StProbe: begin
        // Read the midpoint entry; its data arrives in the next cycle.
        mid_d   = mid_next;
        state_d = StCmp;
      end
      StCmp: begin
        // Since the set has no duplicates, a present value is always probed
        // on the way to its lower bound.
        if (rd_data_q == val_q) begin
          fnd_d = 1'b1;
        end
        lo_d    = lo_cmp;
        hi_d    = hi_cmp;
        state_d = (lo_cmp < hi_cmp) ? StProbe : StDecide;
      end
      StDecide: begin
        k_d     = count_q;
        state_d = StDone;
        if (!fnd_q && cmd_q == ssm_pkg::CmdInsert) begin
          if (count_q >= CapCount) begin
            ovf_d = 1'b1;
          end else if (count_q == lo_q) begin
            // The new value goes at the end: write it straight away.
            mem_we    = 1'b1;
            mem_waddr = lo_q[AW-1:0];
            mem_wdata = val_q;
            count_d   = count_q + CW'(1);
          end else begin
            state_d = StShRd;
          end
        end
      end
      StShRd: begin
        mem_raddr = k_dec[AW-1:0];
        state_d   = StShWr;
      end
      StShWr: begin
        // Move one entry up by one place.
        mem_we    = 1'b1;
        mem_waddr = k_q[AW-1:0];
        mem_wdata = rd_data_q;
        k_d       = k_dec;
        state_d   = (k_dec == lo_q) ? StFill : StShRd;
      end
      StFill: begin
        // The gap at the lower bound is open: write the new value there.
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
        state_d   = StDone;
      end
      StDone: begin
        if (out_load) begin
          res_found_d = fnd_q;
          res_size_d  = ssm_pkg::SizeWidth'(count_q);
          res_ovf_d   = ovf_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    k_q         <= k_d;
    fnd_q       <= fnd_d;
    ovf_q       <= ovf_d;
    res_found_q <= res_found_d;
    res_size_q  <= res_size_d;
    res_ovf_q   <= res_ovf_d;
  end

  // Memory with one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = res_found_q;
  assign set_size_o  = res_size_q;
  assign overflow_o  = res_ovf_q;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for sorted_set_membership_core: clear, insert and query items.
// It needs ssm_pkg for the field widths and command codes. Expected results
// come from a set model inside the testbench.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [ssm_pkg::CmdWidth-1:0]  cmd_t;
  typedef logic [ssm_pkg::SizeWidth-1:0] set_size_t;

  // The unused command code has no name in the package. The block ignores it.
  localparam cmd_t CmdUnused = 2'd3;

  localparam int unsigned SetCapacity  = ssm_pkg::DefaultCapacity;
  localparam int          MinValue     = 32'sh8000_0000;
  localparam int          MaxValue     = 32'sh7fff_ffff;
  localparam int          RandomItems  = 1250;

  // The slowest item is an insert at the front of a set of 63 members, with
  // 6 probes and 63 moved entries. The drain wait covers it with margin.
  localparam int          DrainCycles  = 400;
  localparam int          LimitCycles  = 2_000_000;

  // The receiver stops taking results once, at a fixed cycle after reset,
  // for long enough that the block must refuse new items for a while.
  localparam int          HoldoffStart  = 2000;
  localparam int          HoldoffCycles = 800;

  typedef struct packed {
    cmd_t                                  command;
    logic signed [ssm_pkg::ValueWidth-1:0] value;
  } set_item_t;

  typedef struct packed {
    logic      found;
    set_size_t set_size;
    logic      overflow;
  } set_reply_t;

  // Clock, reset and the block's ports. Every input has a known value from
  // time zero.
  logic                                  clk_i       = 1'b0;
  logic                                  rst_ni      = 1'b0;
  logic                                  in_valid_i  = 1'b0;
  logic                                  in_stall_o;
  cmd_t                                  command_i   = ssm_pkg::CmdClear;
  logic signed [ssm_pkg::ValueWidth-1:0] value_i     = '0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic                                  found_o;
  set_size_t                             set_size_o;
  logic                                  overflow_o;

  // Items wait here until the driver sends them. Each accepted item gets
  // one predicted reply, and replies come back in order.
  set_item_t   pending_items[$];
  set_reply_t  predicted_replies[$];

  // The model of the set. Members stay in ascending order and appear once.
  int          shadow_members[$];

  // The stimulus generator keeps its own rough list of values inserted since
  // the last clear. Queries and repeat inserts pick from it so that they hit
  // members.
  int          recent_inserts[$];
  int unsigned items_queued;

  int unsigned items_sent;
  int unsigned replies_checked;
  int unsigned error_count;
  int unsigned hits_seen;
  int unsigned overflows_seen;
  int unsigned largest_set;
  int unsigned cycle_count;
  logic        holdoff_active = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_set_membership_core #(
    .CAPACITY(SetCapacity)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .set_size_o (set_size_o),
    .overflow_o (overflow_o)
  );

  // Applies one item to the model set and returns the reply that the block
  // must give for it. Found is the membership before the item. A new value
  // offered to a full set is dropped and flags overflow. A clear, or the
  // unused command, never reports a hit.
  function automatic set_reply_t predict_set_reply(input cmd_t command, input int value);
    set_reply_t reply;
    int         pos;
    reply = '0;
    case (command)
      ssm_pkg::CmdClear: begin
        shadow_members.delete();
      end
      ssm_pkg::CmdInsert, ssm_pkg::CmdQuery: begin
        pos = 0;
        while (pos < shadow_members.size() && shadow_members[pos] < value) pos++;
        if (pos < shadow_members.size() && shadow_members[pos] == value) begin
          reply.found = 1'b1;
        end else if (command == ssm_pkg::CmdInsert) begin
          if (shadow_members.size() >= SetCapacity) begin
            reply.overflow = 1'b1;
          end else begin
            shadow_members.insert(pos, value);
          end
        end
      end
      default: begin
      end
    endcase
    reply.set_size = set_size_t'(shadow_members.size());
    return reply;
  endfunction

  task automatic queue_item(input cmd_t command, input int value);
    set_item_t item;
    item.command = command;
    item.value   = value;
    pending_items.push_back(item);
    if (command != CmdUnused) items_queued++;
    if (command == ssm_pkg::CmdClear) begin
      recent_inserts.delete();
    end else if (command == ssm_pkg::CmdInsert && recent_inserts.size() < 100) begin
      recent_inserts.push_back(value);
    end
  endtask

  function automatic int recent_or_random();
    if (recent_inserts.size() == 0) return $urandom;
    return recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
  endfunction

  // A mix of value sources. Full-range values exercise every bit. The narrow
  // window near zero makes duplicates common. The extremes and values seen
  // before test the ends of the order and hits.
  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return int'($urandom_range(0, 16)) - 8;
      6: begin
        case ($urandom_range(0, 4))
          0:       return MinValue;
          1:       return MaxValue;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default:    return recent_or_random();
    endcase
  endfunction

  // Driver. The item on the port is held until it is accepted. Only after
  // that does the driver pick the next item or start a gap. Sends come in
  // bursts of random length, and a short random gap, often but not always, follows each burst.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    set_item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i  <= ssm_pkg::CmdClear;
      value_i    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predicted_replies.push_back(predict_set_reply(command_i, value_i));
        items_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item  = pending_items.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= next_item.command;
          value_i    <= next_item.value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 50);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Hold-off. This block counts its own cycles from reset. It stalls the
  // receiver for one long window while the driver keeps offering items.
  int unsigned holdoff_clock;

  always @(posedge clk_i or negedge rst_ni) begin : receiver_holdoff
    if (!rst_ni) begin
      holdoff_active <= 1'b0;
      holdoff_clock  = 0;
    end else begin
      holdoff_clock++;
      holdoff_active <= (holdoff_clock >= HoldoffStart) &&
                        (holdoff_clock < HoldoffStart + HoldoffCycles);
    end
  end

  // Monitor. Each accepted result is checked against the oldest prediction.
  // The stall pattern runs in phases of random length. A phase never stalls,
  // stalls about a third of the time, or stalls about three quarters of the
  // time.
  int unsigned stall_mode;
  int unsigned stall_phase_left;

  always @(posedge clk_i or negedge rst_ni) begin : reply_monitor
    set_reply_t want;
    logic       stall_now;
    if (!rst_ni) begin
      out_stall_i      <= 1'b0;
      stall_mode       = 0;
      stall_phase_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("result arrived with no item outstanding");
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (found_o !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_o);
            error_count++;
          end
          if (set_size_o !== want.set_size) begin
            $error("set_size: expected %0d, got %0d", want.set_size, set_size_o);
            error_count++;
          end
          if (overflow_o !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow_o);
            error_count++;
          end
          if (want.found) hits_seen++;
          if (want.overflow) overflows_seen++;
          if (want.set_size > largest_set) largest_set = want.set_size;
        end
        replies_checked++;
      end
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(0, 2);
        stall_phase_left = $urandom_range(20, 200);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        0:       stall_now = 1'b0;
        1:       stall_now = ($urandom_range(0, 2) == 0);
        default: stall_now = ($urandom_range(0, 3) != 0);
      endcase
      out_stall_i <= stall_now || holdoff_active;
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, predicted_replies.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run. All items are queued at time zero, and then
  // reset is released.
  initial begin : stimulus
    int unsigned fill_count;
    int unsigned mixed_count;
    int unsigned pick;
    int          v;
    logic        first_episode;

    // Directed opening items. The comments name the special cases that they cover.
    queue_item(ssm_pkg::CmdQuery, 0);          // a query on the empty set misses
    queue_item(ssm_pkg::CmdInsert, 0);
    queue_item(ssm_pkg::CmdInsert, MinValue);  // the new member goes below all others
    queue_item(ssm_pkg::CmdInsert, MaxValue);  // the new member goes above all others
    queue_item(ssm_pkg::CmdInsert, 0);         // a duplicate insert reports a hit
    queue_item(ssm_pkg::CmdQuery, MinValue);
    queue_item(ssm_pkg::CmdQuery, MaxValue);
    queue_item(ssm_pkg::CmdQuery, -1);         // misses, sits between two members
    queue_item(ssm_pkg::CmdInsert, -1);        // the new member goes in the middle
    queue_item(ssm_pkg::CmdInsert, 1);
    queue_item(ssm_pkg::CmdInsert, MinValue + 1);
    queue_item(ssm_pkg::CmdQuery, MaxValue - 1);
    queue_item(CmdUnused, 5);                  // the unused command leaves the set alone
    queue_item(ssm_pkg::CmdQuery, 5);
    queue_item(CmdUnused, MinValue);
    queue_item(ssm_pkg::CmdClear, MaxValue);   // clear ignores its value
    queue_item(ssm_pkg::CmdQuery, 0);          // the set is empty again after the clear
    queue_item(ssm_pkg::CmdClear, 0);          // a clear on an empty set
    queue_item(ssm_pkg::CmdInsert, -2);

    // Random part. Most episodes are well formed: usually a clear, a fill of chosen
    // depth, then a mix of queries and inserts that often hit members. The
    // first episode fills past capacity so that the full-set cases come
    // early. The rest, about three in ten, are noise with random commands.
    items_queued  = 0;
    first_episode = 1'b1;
    while (items_queued < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (first_episode || pick < 7) begin
        if (first_episode || $urandom_range(0, 9) != 0) begin
          queue_item(ssm_pkg::CmdClear, $urandom);
        end
        if (first_episode) begin
          fill_count = 75;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2:    fill_count = $urandom_range(0, 8);
            3, 4, 5, 6: fill_count = $urandom_range(8, 50);
            default:    fill_count = $urandom_range(55, 80);
          endcase
        end
        for (int unsigned n = 0; n < fill_count; n++) begin
          if (first_episode || $urandom_range(0, 2) != 0) v = $urandom;
          else v = int'($urandom_range(0, 99)) - 50;
          queue_item(ssm_pkg::CmdInsert, v);
        end
        mixed_count = $urandom_range(5, 40);
        for (int unsigned n = 0; n < mixed_count; n++) begin
          pick = $urandom_range(0, 99);
          if (pick < 40)      queue_item(ssm_pkg::CmdQuery, recent_or_random());
          else if (pick < 55) queue_item(ssm_pkg::CmdQuery, pick_value());
          else if (pick < 75) queue_item(ssm_pkg::CmdInsert, pick_value());
          else if (pick < 85) queue_item(ssm_pkg::CmdInsert, recent_or_random());
          else if (pick < 90) begin
            queue_item(ssm_pkg::CmdQuery,
                       ($urandom_range(0, 1) != 0) ? MinValue : MaxValue);
          end
          else if (pick < 95) queue_item(CmdUnused, $urandom);
          else                queue_item(ssm_pkg::CmdClear, $urandom);
        end
        first_episode = 1'b0;
      end else begin
        mixed_count = $urandom_range(10, 30);
        for (int unsigned n = 0; n < mixed_count; n++) begin
          queue_item(cmd_t'($urandom_range(0, 3)), pick_value());
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (predicted_replies.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_replies.size());
      error_count++;
    end

    $display("Checked %0d results for %0d accepted items: %0d hits, %0d dropped inserts.",
             replies_checked, items_sent, hits_seen, overflows_seen);
    $display("Largest set reached %0d of %0d members; receiver held off for %0d cycles once.",
             largest_set, SetCapacity, HoldoffCycles);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
